// ===== hdl/pmd_pkg.sv =====
// Package for the PPM decoder and motor drive block.
// Shared types, register indexes, reset values and drive codes.
// No dependencies.
package pmd_pkg;

  localparam int NumChannelsDef = 8;
  localparam int QueueDepthDef  = 2;

  localparam int TimeW  = 16;
  localparam int ChanW  = 4;
  localparam int DirW   = 2;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgWrapTop   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncGap   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseMin  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPulseMax  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFwdThresh = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBwdThresh = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCenter    = 3'd6;

  localparam logic [TimeW-1:0] WrapTopRst   = 16'd39999;
  localparam logic [TimeW-1:0] SyncGapRst   = 16'd10000;
  localparam logic [TimeW-1:0] PulseMinRst  = 16'd2000;
  localparam logic [TimeW-1:0] PulseMaxRst  = 16'd4000;
  localparam logic [TimeW-1:0] FwdThreshRst = 16'd3100;
  localparam logic [TimeW-1:0] BwdThreshRst = 16'd2900;
  localparam logic [TimeW-1:0] CenterRst    = 16'd3000;

  localparam logic [ChanW-1:0] ChanNone     = 4'd0;
  localparam logic [ChanW-1:0] ChanThrottle = 4'd2;
  localparam logic [ChanW-1:0] ChanSteer    = 4'd4;

  localparam logic [DirW-1:0] DirStop = 2'd0;
  localparam logic [DirW-1:0] DirFwd  = 2'd1;
  localparam logic [DirW-1:0] DirBwd  = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] wrap_top;
    logic [TimeW-1:0] sync_gap;
    logic [TimeW-1:0] pulse_min;
    logic [TimeW-1:0] pulse_max;
    logic [TimeW-1:0] forward_threshold;
    logic [TimeW-1:0] backward_threshold;
    logic [TimeW-1:0] throttle_center;
  } pmd_cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [TimeW-1:0] width;
  } pmd_item_t;

  typedef struct packed {
    logic [TimeW-1:0] servo_duty;
    logic [TimeW-1:0] motor_duty;
    logic [DirW-1:0]  motor_dir;
    logic [TimeW-1:0] pulse_width;
    logic [ChanW-1:0] channel_number;
  } pmd_result_t;

endpackage

// ===== hdl/pmd_queue.sv =====
// Small register queue between the front and back parts.
// Depends on nothing but its parameters (Depth a power of two, at least 2).
module pmd_queue #(
  parameter int Width = 20,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/pmd_front.sv =====
// Front part: measures the interval between edges, clamps it and
// assigns the channel slot. Depends on pmd_pkg.
module pmd_front
  import pmd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pmd_cfg_t         cfg_i,
  input  logic             accept_i,
  input  logic [TimeW-1:0] edge_time_i,
  output pmd_item_t        item_o
);

  localparam logic [ChanW-1:0] ChanLast = ChanW'(NUM_CHANNELS + 1);
  localparam logic [ChanW-1:0] ChanMax  = ChanW'(NUM_CHANNELS);

  logic             edge_seen_q, edge_seen_d;
  logic [TimeW-1:0] last_q, last_d;
  logic [ChanW-1:0] cnt_q, cnt_d;

  logic signed [TimeW+1:0] term;
  logic [TimeW:0]          span;
  logic [TimeW-1:0]        width;
  logic [ChanW-1:0]        cnt_eff;

  always_comb begin
    if (last_q > edge_time_i) begin
      term = $signed({2'b00, cfg_i.wrap_top}) - $signed({2'b00, last_q})
           + $signed({2'b00, edge_time_i});
    end else begin
      term = $signed({2'b00, edge_time_i}) - $signed({2'b00, last_q});
    end
    span = term[TimeW+1] ? '0 : term[TimeW:0];

    if (span > {1'b0, cfg_i.pulse_max}) begin
      width = cfg_i.pulse_max;
    end else if (span < {1'b0, cfg_i.pulse_min}) begin
      width = cfg_i.pulse_min;
    end else begin
      width = span[TimeW-1:0];
    end

    cnt_eff = (span > {1'b0, cfg_i.sync_gap}) ? ChanLast : cnt_q;

    edge_seen_d = edge_seen_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    item_o.chan  = ChanNone;
    item_o.width = '0;
    if (accept_i) begin
      edge_seen_d = 1'b1;
      last_d      = edge_time_i;
      if (edge_seen_q) begin
        item_o.width = width;
        if (cnt_eff >= 4'd1 && cnt_eff <= ChanMax) begin
          item_o.chan = cnt_eff;
          cnt_d       = cnt_eff + 1'b1;
        end else begin
          item_o.chan = ChanLast;
          cnt_d       = 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_seen_q <= 1'b0;
      last_q      <= '0;
      cnt_q       <= 4'd1;
    end else begin
      edge_seen_q <= edge_seen_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
    end
  end

endmodule

// ===== hdl/pmd_back.sv =====
// Back part: updates motor and servo drive state from classified items
// and holds the output register. Depends on pmd_pkg.
module pmd_back
  import pmd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pmd_cfg_t    cfg_i,
  input  logic        empty_i,
  input  pmd_item_t   item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pmd_result_t result_o
);

  localparam logic [ChanW-1:0] ChanMax = ChanW'(NUM_CHANNELS);

  logic [DirW-1:0]  dir_q, dir_d;
  logic [TimeW-1:0] duty_q, duty_d, servo_q, servo_d;
  logic             valid_q, valid_d;
  pmd_result_t      res_q, res_d;

  logic [TimeW-1:0] hi, lo, delta;
  logic [TimeW+5:0] scaled;
  logic [TimeW-1:0] sat_duty;
  logic             fwd, bwd;

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    fwd = item_i.width > cfg_i.forward_threshold;
    bwd = item_i.width < cfg_i.backward_threshold;
    hi  = fwd ? item_i.width : cfg_i.throttle_center;
    lo  = fwd ? cfg_i.throttle_center : item_i.width;
    delta = (hi > lo) ? hi - lo : '0;
    scaled = {1'b0, delta, 5'b0} + {3'b0, delta, 3'b0};
    sat_duty = (scaled > (TimeW+6)'(16'hFFFF)) ? 16'hFFFF : scaled[TimeW-1:0];

    dir_d   = dir_q;
    duty_d  = duty_q;
    servo_d = servo_q;
    if (item_i.chan == ChanThrottle && ChanThrottle <= ChanMax) begin
      if (fwd) begin
        dir_d  = DirFwd;
        duty_d = sat_duty;
      end else if (bwd) begin
        dir_d  = DirBwd;
        duty_d = sat_duty;
      end else begin
        dir_d  = DirStop;
        duty_d = '0;
      end
    end else if (item_i.chan == ChanSteer && ChanSteer <= ChanMax) begin
      servo_d = item_i.width;
    end

    res_d.channel_number = item_i.chan;
    res_d.pulse_width    = item_i.width;
    res_d.motor_dir      = dir_d;
    res_d.motor_duty     = duty_d;
    res_d.servo_duty     = servo_d;

    valid_d = pop_o || (valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DirStop;
      duty_q  <= '0;
      servo_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (pop_o) begin
        dir_q   <= dir_d;
        duty_q  <= duty_d;
        servo_q <= servo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// ===== hdl/ppm_decode_motor_drive_core.sv =====
// Top level of the PPM decoder with DC motor and servo drive.
// Depends on pmd_pkg, pmd_front, pmd_queue and pmd_back.
//
// Usage:
//   s_axis carries one falling-edge timer count per transaction
//   (tdata[15:0] edge_time). m_axis returns one result per edge.
//   The cfg channel writes the seven 16-bit registers by index; it is
//   always ready and should only be used while the block is idle.
//   Path of an edge: the front writes the queue at the accepting edge,
//   and the output register loads the item when the back pops it, which
//   waits while m_axis stalls with a result still held.
//   Throughput: one edge per cycle while m_axis does not stall; the front
//   computes interval, clamp and slot combinationally, the back the duty.
//   A two-entry queue separates the parts; when m_axis stalls the queue
//   fills and s_axis_tready drops only once both entries are taken.
//   Reset: registers return to their defaults, the first edge after
//   reset only captures time and reports channel 0, width 0 and the
//   held drive values (all zero).
module ppm_decode_motor_drive_core
  import pmd_pkg::*;
#(
  parameter int NUM_CHANNELS = NumChannelsDef,
  parameter int QUEUE_DEPTH  = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] edge_time
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [3:0] channel_number, [19:4] pulse_width, [21:20] motor_dir,
  // [37:22] motor_duty, [53:38] servo_duty, [55:54] zero
  output logic [55:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimeW-1:0]   cfg_data_i
);

  localparam int ItemW = $bits(pmd_item_t);

  pmd_cfg_t    cfg_q;
  pmd_item_t   front_item, queue_item;
  pmd_result_t result;
  logic        accept, q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_top           <= WrapTopRst;
      cfg_q.sync_gap           <= SyncGapRst;
      cfg_q.pulse_min          <= PulseMinRst;
      cfg_q.pulse_max          <= PulseMaxRst;
      cfg_q.forward_threshold  <= FwdThreshRst;
      cfg_q.backward_threshold <= BwdThreshRst;
      cfg_q.throttle_center    <= CenterRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgWrapTop:   cfg_q.wrap_top           <= cfg_data_i;
        CfgSyncGap:   cfg_q.sync_gap           <= cfg_data_i;
        CfgPulseMin:  cfg_q.pulse_min          <= cfg_data_i;
        CfgPulseMax:  cfg_q.pulse_max          <= cfg_data_i;
        CfgFwdThresh: cfg_q.forward_threshold  <= cfg_data_i;
        CfgBwdThresh: cfg_q.backward_threshold <= cfg_data_i;
        CfgCenter:    cfg_q.throttle_center    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  pmd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .edge_time_i(s_axis_tdata),
    .item_o     (front_item)
  );

  pmd_queue #(
    .Width(ItemW),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (queue_item),
    .empty_o(q_empty)
  );

  pmd_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (q_empty),
    .item_i     (queue_item),
    .pop_o      (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .result_o   (result)
  );

  assign m_axis_tdata = {2'b00, result};

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> result.channel_number <= ChanW'(NUM_CHANNELS + 1))
    else $error("channel number out of range");

  a_first_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.channel_number == ChanNone) |-> result.pulse_width == '0)
    else $error("first edge carries a width");

  a_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.motor_dir == DirStop) |-> result.motor_duty == '0)
    else $error("stopped motor with nonzero duty");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result.motor_dir == DirStop || result.motor_dir == DirFwd
                       || result.motor_dir == DirBwd))
    else $error("invalid motor direction");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !q_empty))
    else $error("input stalled without backlog");

endmodule
